>>> hdl/kmeans_cluster_engine_top_assert.svh
// Assertion macros for the k-means cluster engine.
// Used by kmeans_cluster_engine_top; no other dependencies.
`ifndef KMEANS_CLUSTER_ENGINE_TOP_ASSERT_SVH
`define KMEANS_CLUSTER_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define KCE_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KCE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/kce_pkg.sv
// Shared constants, codes and transaction types of the k-means cluster engine.
// No dependencies.
package kce_pkg;

   localparam int MAX_POINTS   = 1024;
   localparam int DIM          = 4;
   localparam int MAX_CLUSTERS = 8;

   localparam int PT_DEPTH = MAX_POINTS * DIM;
   localparam int MN_DEPTH = MAX_CLUSTERS * DIM;
   localparam int PT_AW    = $clog2(PT_DEPTH);
   localparam int MN_AW    = $clog2(MN_DEPTH);
   localparam int PIDX_W   = $clog2(MAX_POINTS);
   localparam int CIDX_W   = $clog2(MAX_CLUSTERS);
   localparam int DIDX_W   = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int CNT_W    = $clog2(MAX_POINTS + 1);

   localparam int NP_W   = 11;
   localparam int NC_W   = 4;
   localparam int IT_W   = 8;
   localparam int VAL_W  = 16;
   localparam int SUM_W  = 27;
   localparam int TOT_W  = 47;
   localparam int MAG_W  = VAL_W + 1;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int DIST_W = SQ_W + $clog2(DIM + 1);
   localparam int DCNT_W = $clog2(SUM_W + 1);

   localparam logic [2:0] CMD_LOAD_POINT = 3'd0;
   localparam logic [2:0] CMD_LOAD_MEAN  = 3'd1;
   localparam logic [2:0] CMD_START      = 3'd2;
   localparam logic [2:0] CMD_READ_ASG   = 3'd3;
   localparam logic [2:0] CMD_READ_MEAN  = 3'd4;

   localparam logic [1:0] KIND_RUN_DONE = 2'd0;
   localparam logic [1:0] KIND_ASG      = 2'd1;
   localparam logic [1:0] KIND_MEAN     = 2'd2;

   localparam logic [1:0] REG_NUM_POINTS   = 2'd0;
   localparam logic [1:0] REG_NUM_CLUSTERS = 2'd1;
   localparam logic [1:0] REG_MAX_ITER     = 2'd2;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [9:0]         item_index;
      logic [1:0]         coord_index;
      logic signed [15:0] coord_value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         cluster;
      logic signed [15:0] mean_value;
      logic [7:0]         rounds_used;
      logic [46:0]        total_distance;
   } rsp_payload_type;

endpackage

>>> hdl/kce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/kmeans_cluster_engine_top.sv
// Lloyd k-means engine: point, mean and assignment stores with one shared
// distance/accumulate datapath and a bit-serial divider. Uses kce_pkg, kce_ram
// and kmeans_cluster_engine_top_assert.svh.

// Loads are accepted one per cycle, back to back, while the engine is idle;
// queries read the addressed store, then wait for a free result slot. A start
// command runs up to max_iterations rounds; each round runs the distance loop
// (address, difference, multiply, accumulate; one multiplier shared over all
// coordinates), rebuilds the cluster sums over the single point-store read
// port, and divides each coordinate of each non-empty cluster in the 27-step
// divider. After reset all MAX_POINTS (1024) assignment entries are cleared,
// accepting no transaction meanwhile; register writes are taken as ever.
module kmeans_cluster_engine_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  kce_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output kce_pkg::rsp_payload_type rsp_payload,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [3:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import kce_pkg::*;

   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_QRY     = 5'd2;
   localparam logic [4:0] S_QOUT    = 5'd3;
   localparam logic [4:0] S_RSTART  = 5'd4;
   localparam logic [4:0] S_A_ADDR  = 5'd5;
   localparam logic [4:0] S_A_DIFF  = 5'd6;
   localparam logic [4:0] S_A_MUL   = 5'd7;
   localparam logic [4:0] S_A_ACC   = 5'd8;
   localparam logic [4:0] S_RND_END = 5'd9;
   localparam logic [4:0] S_RC_ADDR = 5'd10;
   localparam logic [4:0] S_RC_ACC  = 5'd11;
   localparam logic [4:0] S_DV_SEL  = 5'd12;
   localparam logic [4:0] S_DV_STEP = 5'd13;
   localparam logic [4:0] S_DV_WR   = 5'd14;
   localparam logic [4:0] S_DONE    = 5'd15;

   logic [4:0]        state_ff, state_in;
   logic [NP_W-1:0]   np_cfg_ff, np_cfg_in;
   logic [NC_W-1:0]   nc_cfg_ff, nc_cfg_in;
   logic [IT_W-1:0]   mi_cfg_ff, mi_cfg_in;
   logic [PIDX_W-1:0] p_ff, p_in;
   logic [CIDX_W-1:0] c_ff, c_in;
   logic [DIDX_W-1:0] d_ff, d_in;
   logic [IT_W-1:0]   it_ff, it_in;
   logic [IT_W-1:0]   rounds_ff, rounds_in;
   logic [DIST_W-1:0] acc_ff, acc_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic [CIDX_W-1:0] bi_ff, bi_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [TOT_W-1:0]  prev_ff, prev_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic signed [SUM_W-1:0] sums_ff [MN_DEPTH];
   logic signed [SUM_W-1:0] sums_in [MN_DEPTH];
   logic [CNT_W-1:0]  cnts_ff [MAX_CLUSTERS];
   logic [CNT_W-1:0]  cnts_in [MAX_CLUSTERS];
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              dneg_ff, dneg_in;
   logic [1:0]        qkind_ff, qkind_in;
   logic              qok_ff, qok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   logic [NP_W-1:0]   np_act;
   logic [NC_W-1:0]   nc_act;
   logic              accept, slot_free;
   logic              d_last, c_last, p_last;
   logic [PT_AW-1:0]  pt_idx;
   logic [MN_AW-1:0]  mn_idx;
   logic [MN_AW-1:0]  sum_idx;
   logic              pt_we, mn_we, asg_we;
   logic [PT_AW-1:0]  pt_waddr;
   logic [MN_AW-1:0]  mn_waddr, mn_raddr;
   logic [PIDX_W-1:0] asg_waddr, asg_raddr;
   logic [VAL_W-1:0]  pt_wdata, mn_wdata, pt_rdata, mn_rdata;
   logic [CIDX_W-1:0] asg_wdata, asg_rdata;
   logic signed [MAG_W-1:0] diff;
   logic [DIST_W-1:0] acc_sum;
   logic              better;
   logic [DIST_W-1:0] best_new;
   logic [CIDX_W-1:0] bi_new;
   logic [CNT_W:0]    rem_try;
   logic [SUM_W-1:0]  quo_signed;
   logic signed [SUM_W-1:0] sum_sel;
   logic              cfg_wr;

   assign np_act = (np_cfg_ff > NP_W'(MAX_POINTS)) ? NP_W'(MAX_POINTS) : np_cfg_ff;
   assign nc_act = (nc_cfg_ff == '0) ? NC_W'(1) :
                   (nc_cfg_ff > NC_W'(MAX_CLUSTERS)) ? NC_W'(MAX_CLUSTERS) : nc_cfg_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign d_last = (d_ff == DIDX_W'(DIM - 1));
   assign c_last = ((NC_W'(c_ff) + NC_W'(1)) == nc_act);
   assign p_last = ((NP_W'(p_ff) + NP_W'(1)) == np_act);

   assign pt_idx  = PT_AW'(PT_AW'(p_ff) * PT_AW'(DIM) + PT_AW'(d_ff));
   assign mn_idx  = MN_AW'(MN_AW'(c_ff) * MN_AW'(DIM) + MN_AW'(d_ff));
   assign sum_idx = MN_AW'(MN_AW'(asg_rdata) * MN_AW'(DIM) + MN_AW'(d_ff));

   // configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      np_cfg_in = np_cfg_ff;
      nc_cfg_in = nc_cfg_ff;
      mi_cfg_in = mi_cfg_ff;
      if (cfg_wr) begin
         case (paddr[3:2])
            REG_NUM_POINTS:   np_cfg_in = pwdata[NP_W-1:0];
            REG_NUM_CLUSTERS: nc_cfg_in = pwdata[NC_W-1:0];
            REG_MAX_ITER:     mi_cfg_in = pwdata[IT_W-1:0];
            default:          np_cfg_in = np_cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_NUM_POINTS:   prdata = 32'(np_cfg_ff);
         REG_NUM_CLUSTERS: prdata = 32'(nc_cfg_ff);
         REG_MAX_ITER:     prdata = 32'(mi_cfg_ff);
         default:          prdata = '0;
      endcase
   end

   // store ports
   assign pt_we    = accept && (req_payload.cmd == CMD_LOAD_POINT) &&
                     (32'(req_payload.coord_index) < DIM) &&
                     (32'(req_payload.item_index) < MAX_POINTS);
   assign pt_waddr = PT_AW'(PT_AW'(req_payload.item_index) * PT_AW'(DIM) +
                     PT_AW'(req_payload.coord_index));
   assign pt_wdata = req_payload.coord_value;

   assign mn_raddr = (state_ff == S_IDLE) ?
                     MN_AW'(MN_AW'(req_payload.item_index) * MN_AW'(DIM) +
                            MN_AW'(req_payload.coord_index)) : mn_idx;
   assign asg_raddr = (state_ff == S_IDLE) ? PIDX_W'(req_payload.item_index) : p_ff;

   kce_ram #(.WIDTH(VAL_W), .DEPTH(PT_DEPTH)) u_point_ram (
      .clock(clock), .wr_en(pt_we), .wr_addr(pt_waddr), .wr_data(pt_wdata),
      .rd_addr(pt_idx), .rd_data(pt_rdata));

   kce_ram #(.WIDTH(VAL_W), .DEPTH(MN_DEPTH)) u_mean_ram (
      .clock(clock), .wr_en(mn_we), .wr_addr(mn_waddr), .wr_data(mn_wdata),
      .rd_addr(mn_raddr), .rd_data(mn_rdata));

   kce_ram #(.WIDTH(CIDX_W), .DEPTH(MAX_POINTS)) u_asg_ram (
      .clock(clock), .wr_en(asg_we), .wr_addr(asg_waddr), .wr_data(asg_wdata),
      .rd_addr(asg_raddr), .rd_data(asg_rdata));

   // datapath helpers
   assign diff     = $signed({pt_rdata[VAL_W-1], pt_rdata}) -
                     $signed({mn_rdata[VAL_W-1], mn_rdata});
   assign acc_sum  = acc_ff + DIST_W'(sq_ff);
   assign better   = (c_ff == '0) || (acc_sum < best_ff);
   assign best_new = better ? acc_sum : best_ff;
   assign bi_new   = better ? c_ff : bi_ff;
   assign rem_try  = {rem_ff, quo_ff[SUM_W-1]};
   assign quo_signed = dneg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;
   assign sum_sel  = sums_ff[mn_idx];

   always_comb begin
      state_in   = state_ff;
      p_in       = p_ff;
      c_in       = c_ff;
      d_in       = d_ff;
      it_in      = it_ff;
      rounds_in  = rounds_ff;
      acc_in     = acc_ff;
      best_in    = best_ff;
      bi_in      = bi_ff;
      total_in   = total_ff;
      prev_in    = prev_ff;
      mag_in     = mag_ff;
      sq_in      = sq_ff;
      sums_in    = sums_ff;
      cnts_in    = cnts_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dcnt_in    = dcnt_ff;
      dneg_in    = dneg_ff;
      qkind_in   = qkind_ff;
      qok_in     = qok_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      mn_we     = 1'b0;
      mn_waddr  = MN_AW'(MN_AW'(req_payload.item_index) * MN_AW'(DIM) +
                         MN_AW'(req_payload.coord_index));
      mn_wdata  = req_payload.coord_value;
      asg_we    = 1'b0;
      asg_waddr = p_ff;
      asg_wdata = '0;

      case (state_ff)
         S_CLEAR: begin
            asg_we = 1'b1;
            p_in   = p_ff + PIDX_W'(1);
            if (32'(p_ff) == MAX_POINTS - 1) begin
               p_in     = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_payload.cmd)
                  CMD_LOAD_MEAN: begin
                     mn_we = (32'(req_payload.item_index) < MAX_CLUSTERS) &&
                             (32'(req_payload.coord_index) < DIM);
                  end
                  CMD_START: begin
                     prev_in   = '0;
                     rounds_in = '0;
                     it_in     = '0;
                     total_in  = '0;
                     state_in  = S_RSTART;
                  end
                  CMD_READ_ASG: begin
                     qkind_in = KIND_ASG;
                     qok_in   = (32'(req_payload.item_index) < MAX_POINTS);
                     state_in = S_QRY;
                  end
                  CMD_READ_MEAN: begin
                     qkind_in = KIND_MEAN;
                     qok_in   = (32'(req_payload.item_index) < MAX_CLUSTERS) &&
                                (32'(req_payload.coord_index) < DIM);
                     state_in = S_QRY;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_QRY: begin
            rsp_payload_in      = '0;
            rsp_payload_in.kind = qkind_ff;
            if (qok_ff && qkind_ff == KIND_ASG) begin
               rsp_payload_in.cluster = 3'(asg_rdata);
            end
            if (qok_ff && qkind_ff == KIND_MEAN) begin
               rsp_payload_in.mean_value = mn_rdata;
            end
            // a result is still pending: keep it and park the query data until the slot frees
            if (rsp_valid_ff) begin
               rsp_payload_in = rsp_payload_ff;
               mag_in  = {MAG_W{1'b0}};
               quo_in  = SUM_W'({qok_ff, asg_rdata, mn_rdata});
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
            if (rsp_valid_ff) begin
               state_in = S_QOUT;
            end
         end
         S_QOUT: begin
            if (slot_free) begin
               rsp_payload_in      = '0;
               rsp_payload_in.kind = qkind_ff;
               if (quo_ff[VAL_W + CIDX_W] && qkind_ff == KIND_ASG) begin
                  rsp_payload_in.cluster = 3'(quo_ff[VAL_W +: CIDX_W]);
               end
               if (quo_ff[VAL_W + CIDX_W] && qkind_ff == KIND_MEAN) begin
                  rsp_payload_in.mean_value = quo_ff[VAL_W-1:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RSTART: begin
            p_in     = '0;
            c_in     = '0;
            d_in     = '0;
            acc_in   = '0;
            total_in = '0;
            if (it_ff == mi_cfg_ff) begin
               total_in = total_ff;
               state_in = S_DONE;
            end else if (np_act == '0) begin
               state_in = S_RND_END;
            end else begin
               state_in = S_A_ADDR;
            end
         end
         S_A_ADDR: state_in = S_A_DIFF;
         S_A_DIFF: begin
            mag_in   = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
            state_in = S_A_MUL;
         end
         S_A_MUL: begin
            sq_in    = SQ_W'(mag_ff) * SQ_W'(mag_ff);
            state_in = S_A_ACC;
         end
         S_A_ACC: begin
            state_in = S_A_ADDR;
            if (!d_last) begin
               acc_in = acc_sum;
               d_in   = d_ff + DIDX_W'(1);
            end else begin
               best_in = best_new;
               bi_in   = bi_new;
               acc_in  = '0;
               d_in    = '0;
               if (!c_last) begin
                  c_in = c_ff + CIDX_W'(1);
               end else begin
                  asg_we    = 1'b1;
                  asg_wdata = bi_new;
                  total_in  = total_ff + TOT_W'(best_new);
                  c_in      = '0;
                  if (p_last) begin
                     state_in = S_RND_END;
                  end else begin
                     p_in = p_ff + PIDX_W'(1);
                  end
               end
            end
         end
         S_RND_END: begin
            rounds_in = rounds_ff + IT_W'(1);
            p_in = '0;
            c_in = '0;
            d_in = '0;
            if (total_ff == prev_ff) begin
               state_in = S_DONE;
            end else begin
               for (int i = 0; i < MN_DEPTH; i++) sums_in[i] = '0;
               for (int i = 0; i < MAX_CLUSTERS; i++) cnts_in[i] = '0;
               state_in = (np_act == '0) ? S_DV_SEL : S_RC_ADDR;
            end
         end
         S_RC_ADDR: state_in = S_RC_ACC;
         S_RC_ACC: begin
            if (NC_W'(asg_rdata) < nc_act) begin
               sums_in[sum_idx] = sums_ff[sum_idx] +
                                  {{(SUM_W-VAL_W){pt_rdata[VAL_W-1]}}, pt_rdata};
               if (d_last) begin
                  cnts_in[asg_rdata] = cnts_ff[asg_rdata] + CNT_W'(1);
               end
            end
            state_in = S_RC_ADDR;
            if (!d_last) begin
               d_in = d_ff + DIDX_W'(1);
            end else begin
               d_in = '0;
               if (p_last) begin
                  p_in     = '0;
                  state_in = S_DV_SEL;
               end else begin
                  p_in = p_ff + PIDX_W'(1);
               end
            end
         end
         S_DV_SEL: begin
            if (cnts_ff[c_ff] == '0) begin
               d_in = '0;
               if (c_last) begin
                  c_in     = '0;
                  prev_in  = total_ff;
                  it_in    = it_ff + IT_W'(1);
                  state_in = S_RSTART;
               end else begin
                  c_in = c_ff + CIDX_W'(1);
               end
            end else begin
               dneg_in  = sum_sel[SUM_W-1];
               quo_in   = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
               rem_in   = '0;
               dcnt_in  = DCNT_W'(SUM_W);
               state_in = S_DV_STEP;
            end
         end
         S_DV_STEP: begin
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            rem_in = rem_try[CNT_W-1:0];
            if (rem_try >= {1'b0, cnts_ff[c_ff]}) begin
               rem_in    = CNT_W'(rem_try - {1'b0, cnts_ff[c_ff]});
               quo_in[0] = 1'b1;
            end
            dcnt_in = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(1)) begin
               state_in = S_DV_WR;
            end
         end
         S_DV_WR: begin
            mn_we    = 1'b1;
            mn_waddr = mn_idx;
            mn_wdata = quo_signed[VAL_W-1:0];
            state_in = S_DV_SEL;
            if (!d_last) begin
               d_in = d_ff + DIDX_W'(1);
            end else begin
               d_in = '0;
               if (c_last) begin
                  c_in     = '0;
                  prev_in  = total_ff;
                  it_in    = it_ff + IT_W'(1);
                  state_in = S_RSTART;
               end else begin
                  c_in = c_ff + CIDX_W'(1);
               end
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_payload_in                = '0;
               rsp_payload_in.kind           = KIND_RUN_DONE;
               rsp_payload_in.rounds_used    = rounds_ff;
               rsp_payload_in.total_distance = total_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         np_cfg_ff    <= NP_W'(1024);
         nc_cfg_ff    <= NC_W'(2);
         mi_cfg_ff    <= IT_W'(16);
         p_ff         <= '0;
         c_ff         <= '0;
         d_ff         <= '0;
         it_ff        <= '0;
         rounds_ff    <= '0;
         total_ff     <= '0;
         prev_ff      <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MN_DEPTH; i++) sums_ff[i] <= '0;
         for (int i = 0; i < MAX_CLUSTERS; i++) cnts_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         np_cfg_ff    <= np_cfg_in;
         nc_cfg_ff    <= nc_cfg_in;
         mi_cfg_ff    <= mi_cfg_in;
         p_ff         <= p_in;
         c_ff         <= c_in;
         d_ff         <= d_in;
         it_ff        <= it_in;
         rounds_ff    <= rounds_in;
         total_ff     <= total_in;
         prev_ff      <= prev_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         sums_ff      <= sums_in;
         cnts_ff      <= cnts_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff         <= acc_in;
      best_ff        <= best_in;
      bi_ff          <= bi_in;
      mag_ff         <= mag_in;
      sq_ff          <= sq_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      dneg_ff        <= dneg_in;
      qkind_ff       <= qkind_in;
      qok_ff         <= qok_in;
      rsp_payload_ff <= rsp_payload_in;
   end

`include "kmeans_cluster_engine_top_assert.svh"

   `KCE_ASSERT_IMPLY(a_clear_quiet, clock, reset, state_ff == S_CLEAR, !rsp_valid_ff, "result during clearing pass")
   `KCE_ASSERT_IMPLY(a_div_live, clock, reset, state_ff == S_DV_STEP, dcnt_ff != '0, "divider step count ran out")
   `KCE_ASSERT_IMPLY(a_asg_range, clock, reset, asg_we && state_ff == S_A_ACC, NC_W'(asg_wdata) < nc_act, "assignment beyond active clusters")
   `KCE_ASSERT_NEXT(a_div_end, clock, reset, state_ff == S_DV_STEP && dcnt_ff == DCNT_W'(1), state_ff == S_DV_WR, "divider did not finish")

endmodule
